>>> rtl/tsws_pkg.sv
// ----------------------------------------------------------------------------
// tsws_pkg
// Types and constants shared by the target sum window search unit.
// ----------------------------------------------------------------------------
package tsws_pkg;

	localparam int MAX_ELEMENTS = 1024;
	localparam int IDX_W = $clog2(MAX_ELEMENTS);
	localparam int CNT_W = IDX_W + 1;
	localparam int VALUE_W = 16;
	localparam int TARGET_W = 32;
	localparam int SUM_W = TARGET_W + 1;
	localparam int Q_DEPTH = 4;
	localparam int Q_AW = $clog2(Q_DEPTH);

	localparam logic [1:0] ST_FOUND = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_TOO_LONG = 2'd2;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               last;
	} item_t;

	typedef struct packed {
		logic [1:0] status;
		logic [9:0] first_index;
		logic [9:0] last_index;
	} result_t;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               last;
		logic [IDX_W-1:0]   index;
		logic               too_long;
	} q_entry_t;

endpackage

>>> rtl/tsws_ram.sv
// ----------------------------------------------------------------------------
// tsws_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module tsws_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

>>> rtl/tsws_fifo.sv
// ----------------------------------------------------------------------------
// tsws_fifo
// Short queue of classified elements between the front and the back part.
// ----------------------------------------------------------------------------
module tsws_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  tsws_pkg::q_entry_t push_data,
	output logic               full,
	input  logic               pop,
	output tsws_pkg::q_entry_t pop_data,
	output logic               empty
);

	tsws_pkg::q_entry_t             entry_q [tsws_pkg::Q_DEPTH];
	logic [tsws_pkg::Q_AW-1:0]      wr_ptr_q;
	logic [tsws_pkg::Q_AW-1:0]      rd_ptr_q;
	logic [tsws_pkg::Q_AW:0]        count_q;

	assign full = (count_q == (tsws_pkg::Q_AW+1)'(tsws_pkg::Q_DEPTH));
	assign empty = (count_q == '0);
	assign pop_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/tsws_front.sv
// ----------------------------------------------------------------------------
// tsws_front
// Accepts elements, numbers them, writes them to the window store and
// queues them, marked when the array has outgrown the store.
// ----------------------------------------------------------------------------
module tsws_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_ready,
	input  tsws_pkg::item_t               item,
	output logic                          q_push,
	output tsws_pkg::q_entry_t            q_entry,
	input  logic                          q_full,
	output logic                          wr_en,
	output logic [tsws_pkg::IDX_W-1:0]    wr_addr,
	output logic [tsws_pkg::VALUE_W-1:0]  wr_data,
	input  logic                          arr_end
);

	logic [tsws_pkg::CNT_W-1:0] count_q;
	logic                       wait_q;
	logic                       too_long;

	// A new array may not start until the back part has finished the last
	// one, since its store entries are still being read.
	assign item_ready = !wait_q && !q_full;
	assign q_push = item_valid && item_ready;
	assign too_long = (count_q == tsws_pkg::CNT_W'(tsws_pkg::MAX_ELEMENTS));

	assign q_entry.value = item.value;
	assign q_entry.last = item.last;
	assign q_entry.index = count_q[tsws_pkg::IDX_W-1:0];
	assign q_entry.too_long = too_long;

	assign wr_en = q_push && !too_long;
	assign wr_addr = count_q[tsws_pkg::IDX_W-1:0];
	assign wr_data = item.value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			wait_q <= 1'b0;
		end else begin
			if (wait_q) begin
				wait_q <= !arr_end;
			end else begin
				wait_q <= q_push && item.last;
			end
			if (q_push) begin
				if (item.last) begin
					count_q <= '0;
				end else if (!too_long) begin
					count_q <= count_q + 1'b1;
				end
			end
		end
	end

endmodule

>>> rtl/tsws_back.sv
// ----------------------------------------------------------------------------
// tsws_back
// Keeps the window sum, drops elements from the window front one per cycle
// and forms the result of each array.
// ----------------------------------------------------------------------------
module tsws_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_empty,
	input  tsws_pkg::q_entry_t            q_data,
	output logic                          q_pop,
	input  logic [tsws_pkg::TARGET_W-1:0] target,
	output logic [tsws_pkg::IDX_W-1:0]    rd_addr,
	input  logic [tsws_pkg::VALUE_W-1:0]  rd_data,
	output logic                          result_valid,
	input  logic                          result_ready,
	output tsws_pkg::result_t             result,
	output logic                          arr_end
);

	localparam logic S_POP = 1'b0;
	localparam logic S_EVAL = 1'b1;

	logic                         state_q;
	logic [tsws_pkg::SUM_W-1:0]   sum_q;
	logic [tsws_pkg::IDX_W-1:0]   start_q;
	logic                         done_q;
	logic [tsws_pkg::IDX_W-1:0]   index_s1;
	logic                         last_s1;
	logic                         out_valid_q;
	tsws_pkg::result_t            out_q;
	logic                         out_free;
	logic [tsws_pkg::SUM_W-1:0]   target_ext;
	logic                         shrink;
	logic                         match;

	assign out_free = !out_valid_q || result_ready;
	assign target_ext = {1'b0, target};
	assign shrink = (sum_q > target_ext) && (start_q < index_s1);
	assign match = (sum_q == target_ext);
	assign q_pop = (state_q == S_POP) && !q_empty && out_free;
	assign rd_addr = (state_q == S_EVAL && shrink) ? start_q + 1'b1 : start_q;

	assign result_valid = out_valid_q;
	assign result = out_q;

	always_comb begin
		arr_end = 1'b0;
		case (state_q)
			S_POP: arr_end = q_pop && q_data.last && (done_q || q_data.too_long);
			S_EVAL: arr_end = !shrink && last_s1 && out_free;
			default: arr_end = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			index_s1 <= q_data.index;
			last_s1 <= q_data.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_POP;
			sum_q <= '0;
			start_q <= '0;
			done_q <= 1'b0;
			out_valid_q <= 1'b0;
			out_q <= '0;
		end else begin
			if (out_valid_q && result_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_POP: begin
					if (q_pop) begin
						if (!done_q && q_data.too_long) begin
							out_valid_q <= 1'b1;
							out_q <= '{status: tsws_pkg::ST_TOO_LONG,
								first_index: '0, last_index: '0};
							done_q <= 1'b1;
						end else if (!done_q) begin
							sum_q <= sum_q + tsws_pkg::SUM_W'(q_data.value);
							state_q <= S_EVAL;
						end
						if (q_data.last && (done_q || q_data.too_long)) begin
							sum_q <= '0;
							start_q <= '0;
							done_q <= 1'b0;
						end
					end
				end
				S_EVAL: begin
					if (shrink) begin
						sum_q <= sum_q - tsws_pkg::SUM_W'(rd_data);
						start_q <= start_q + 1'b1;
					end else if (out_free) begin
						state_q <= S_POP;
						if (match) begin
							out_valid_q <= 1'b1;
							out_q <= '{status: tsws_pkg::ST_FOUND,
								first_index: start_q, last_index: index_s1};
							done_q <= 1'b1;
						end else if (last_s1) begin
							out_valid_q <= 1'b1;
							out_q <= '{status: tsws_pkg::ST_NOT_FOUND,
								first_index: '0, last_index: '0};
						end
						if (last_s1) begin
							sum_q <= '0;
							start_q <= '0;
							done_q <= 1'b0;
						end
					end
				end
				default: state_q <= S_POP;
			endcase
		end
	end

endmodule

>>> rtl/target_sum_window_search_unit.sv
// ----------------------------------------------------------------------------
// target_sum_window_search_unit
// Finds the first contiguous run of a streamed array whose sum equals the
// configured target and reports its first and last index.
// ----------------------------------------------------------------------------
// The front part takes one element per cycle, unless the queue is full or
// the previous array is unfinished, into a four-entry queue and writes it
// to the 1024-entry window store. The back part takes an element from the
// queue, checks the window and drops elements from the window front while
// the sum exceeds the target; it waits while a result is not yet accepted.
// The first element of a new array is held until the back part has
// finished the last element of the previous array. Elements that follow a
// match or an overflow pass through the queue unchecked. Write the target
// only while the block is idle; the store needs no clearing after reset.
module target_sum_window_search_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_ready,
	input  tsws_pkg::item_t               item,
	output logic                          result_valid,
	input  logic                          result_ready,
	output tsws_pkg::result_t             result,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [tsws_pkg::TARGET_W-1:0] cfg_data
);

	logic [tsws_pkg::TARGET_W-1:0] target_q;
	logic                          q_push;
	logic                          q_pop;
	logic                          q_full;
	logic                          q_empty;
	tsws_pkg::q_entry_t            q_in;
	tsws_pkg::q_entry_t            q_out;
	logic                          wr_en;
	logic [tsws_pkg::IDX_W-1:0]    wr_addr;
	logic [tsws_pkg::VALUE_W-1:0]  wr_data;
	logic [tsws_pkg::IDX_W-1:0]    rd_addr;
	logic [tsws_pkg::VALUE_W-1:0]  rd_data;
	logic                          arr_end;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			target_q <= cfg_data;
		end
	end

	tsws_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.q_push     (q_push),
		.q_entry    (q_in),
		.q_full     (q_full),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.arr_end    (arr_end)
	);

	tsws_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_out),
		.empty     (q_empty)
	);

	tsws_ram #(
		.WIDTH (tsws_pkg::VALUE_W),
		.DEPTH (tsws_pkg::MAX_ELEMENTS)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	tsws_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_data       (q_out),
		.q_pop        (q_pop),
		.target       (target_q),
		.rd_addr      (rd_addr),
		.rd_data      (rd_data),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.arr_end      (arr_end)
	);

	a_zero_index: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status != tsws_pkg::ST_FOUND
		|-> result.first_index == '0 && result.last_index == '0)
		else $error("Index set on a result that is not a match.");

	a_index_order: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status == tsws_pkg::ST_FOUND
		|-> result.first_index <= result.last_index)
		else $error("Match run starts after its end.");

	a_array_gap: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && item.last |=> !item_ready)
		else $error("New array accepted before the previous one finished.");

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Streams arrays of elements through the target sum window search unit
// under a series of target settings and checks every reported window or
// status against a cycle-free prediction of the search.
// ----------------------------------------------------------------------------
module testbench;

	localparam int LIMIT_CYCLES = 1_000_000;
	localparam int DRAIN_CYCLES = 2 * tsws_pkg::MAX_ELEMENTS + 16;
	localparam int HOLD_CYCLES = 400;
	localparam int PHASE_ITEMS = 54;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          item_valid = 1'b0;
	logic                          item_ready;
	tsws_pkg::item_t               item = '0;
	logic                          result_valid;
	logic                          result_ready = 1'b0;
	tsws_pkg::result_t             result;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [tsws_pkg::TARGET_W-1:0] cfg_data = '0;

	tsws_pkg::item_t               elements_due[$];
	tsws_pkg::result_t             answers_due[$];
	logic [tsws_pkg::TARGET_W-1:0] target_writes[$];

	logic [tsws_pkg::VALUE_W-1:0]  run_store [tsws_pkg::MAX_ELEMENTS];
	int                            run_front = 0;
	int                            run_len = 0;
	logic [tsws_pkg::SUM_W-1:0]    run_sum = '0;
	bit                            run_answered = 1'b0;
	logic [tsws_pkg::TARGET_W-1:0] target_now = '0;

	int  cycles = 0;
	int  elements_taken = 0;
	int  arrays_sent = 0;
	int  target_writes_done = 0;
	int  mismatches = 0;
	int  found_seen = 0;
	int  not_found_seen = 0;
	int  too_long_seen = 0;
	bit  send_calm = 1'b0;
	bit  recv_calm = 1'b0;
	bit  hold_req = 1'b0;
	bit  hold_taken = 1'b0;
	int  send_gap = 0;
	int  stall_left = 0;
	int  hold_left = 0;

	target_sum_window_search_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int pick_gap(input bit calm);
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic void search_element(input tsws_pkg::item_t it);
		tsws_pkg::result_t r;
		bit                answer;
		r = '0;
		answer = 1'b0;
		if (!run_answered) begin
			if (run_len >= tsws_pkg::MAX_ELEMENTS) begin
				r.status = tsws_pkg::ST_TOO_LONG;
				answer = 1'b1;
				run_answered = 1'b1;
			end else begin
				run_store[run_len] = it.value;
				run_len++;
				run_sum += it.value;
				while (run_sum > target_now && run_front + 1 < run_len) begin
					run_sum -= run_store[run_front];
					run_front++;
				end
				if (run_sum == target_now) begin
					r.status = tsws_pkg::ST_FOUND;
					r.first_index = 10'(run_front);
					r.last_index = 10'(run_len - 1);
					answer = 1'b1;
					run_answered = 1'b1;
				end else if (it.last) begin
					r.status = tsws_pkg::ST_NOT_FOUND;
					answer = 1'b1;
				end
			end
		end
		if (answer)
			answers_due = {answers_due, r};
		if (it.last) begin
			run_front = 0;
			run_len = 0;
			run_sum = '0;
			run_answered = 1'b0;
		end
	endfunction

	// Element driver: one transfer per free slot, with random gaps between.
	always @(posedge clk) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else begin
			if (item_valid && item_ready) begin
				search_element(item);
				elements_taken++;
			end
			if (!item_valid || item_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					item_valid <= 1'b0;
				end else if (elements_due.size() > 0) begin
					item <= elements_due.pop_front();
					item_valid <= 1'b1;
					send_gap = pick_gap(send_calm);
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			cfg_valid <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				target_now = cfg_data;
				target_writes_done++;
			end
			if (!cfg_valid || cfg_ready) begin
				if (target_writes.size() > 0) begin
					cfg_data <= target_writes.pop_front();
					cfg_valid <= 1'b1;
				end else begin
					cfg_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor and receiver back-pressure.
	always @(posedge clk) begin
		tsws_pkg::result_t want;
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else begin
			if (result_valid && result_ready) begin
				if (answers_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: unexpected result status %0d first %0d last %0d",
							$realtime, result.status, result.first_index, result.last_index);
				end else begin
					want = answers_due.pop_front();
					if (result.status !== want.status ||
						result.first_index !== want.first_index ||
						result.last_index !== want.last_index) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: expected %0d %0d %0d, got %0d %0d %0d",
								$realtime, want.status, want.first_index,
								want.last_index, result.status,
								result.first_index, result.last_index);
					end
					case (want.status)
						tsws_pkg::ST_FOUND:     found_seen++;
						tsws_pkg::ST_NOT_FOUND: not_found_seen++;
						default:                too_long_seen++;
					endcase
				end
			end
			if (hold_req && !hold_taken) begin
				hold_taken = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				result_ready <= 1'b0;
			end else begin
				result_ready <= 1'b1;
				if (!recv_calm && $urandom_range(0, 4) == 0)
					stall_left = pick_gap(1'b0);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("target_sum_window_search_unit verification failed");
			$finish;
		end
	end

	task automatic offer_element(input logic [tsws_pkg::VALUE_W-1:0] v, input logic l);
		tsws_pkg::item_t it;
		it.value = v;
		it.last = l;
		elements_due = {elements_due, it};
		if (l)
			arrays_sent++;
	endtask

	task automatic settle();
		while (elements_due.size() > 0 || item_valid)
			@(negedge clk);
		while (answers_due.size() > 0)
			@(negedge clk);
	endtask

	task automatic write_target(input logic [tsws_pkg::TARGET_W-1:0] t);
		int n;
		settle();
		repeat (DRAIN_CYCLES) @(negedge clk);
		n = target_writes_done;
		target_writes = {target_writes, t};
		while (target_writes_done == n)
			@(negedge clk);
	endtask

	function automatic logic [tsws_pkg::VALUE_W-1:0] pick_value(
		input logic [tsws_pkg::TARGET_W-1:0] t);
		logic [tsws_pkg::TARGET_W-1:0] lim;
		int                            r;
		lim = t / 3;
		if (lim > 65535)
			lim = 65535;
		if (lim == 0)
			lim = 1;
		r = $urandom_range(0, 9);
		if (r < 6)
			return 16'($urandom_range(0, lim));
		if (r < 8)
			return 16'($urandom);
		if (r == 8)
			return '0;
		return (t > 65535) ? 16'hFFFF : t[15:0];
	endfunction

	task automatic random_phase(input logic [tsws_pkg::TARGET_W-1:0] t, input bit hold_here);
		int sent;
		int len;
		int h;
		int k;
		write_target(t);
		send_calm = ($urandom_range(0, 3) == 0);
		recv_calm = ($urandom_range(0, 3) == 0);
		sent = 0;
		for (h = 0; h < 2; h++) begin
			while (sent < PHASE_ITEMS * (h + 1) / 2) begin
				len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
					: $urandom_range(1, 12);
				for (k = 0; k < len; k++)
					offer_element(pick_value(t), k == len - 1);
				sent += len;
			end
			if (h == 0) begin
				if (hold_here)
					hold_req = 1'b1;
				settle();
			end
		end
	endtask

	initial begin
		logic [tsws_pkg::TARGET_W-1:0] targets [10];
		int                            p;
		int                            k;
		targets = '{32'd1, 32'd37, 32'd255, 32'd1000, 32'd65535, 32'd131071,
			$urandom, $urandom, 32'hFFFF_FFFF, 32'd0};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset target is zero: a zero element matches alone, others shrink to one.
		send_calm = 1'b1;
		offer_element(16'd0, 1'b1);
		offer_element(16'd5, 1'b0);
		offer_element(16'd0, 1'b0);
		offer_element(16'd7, 1'b1);
		offer_element(16'hFFFF, 1'b1);
		write_target(32'd10);
		offer_element(16'd3, 1'b0);
		offer_element(16'd4, 1'b0);
		offer_element(16'd3, 1'b1);
		offer_element(16'd20, 1'b0);
		offer_element(16'd10, 1'b1);
		offer_element(16'd1, 1'b0);
		offer_element(16'd2, 1'b1);
		offer_element(16'd10, 1'b0);
		offer_element(16'd1, 1'b0);
		offer_element(16'd2, 1'b1);
		write_target(32'hFFFF_FFFF);
		offer_element(16'hFFFF, 1'b0);
		offer_element(16'hFFFF, 1'b1);

		for (p = 0; p < 5; p++)
			random_phase(targets[p], p == 1);

		// One full store, a final element that drains the whole window, then overflow.
		write_target(32'd65534);
		send_calm = 1'b0;
		recv_calm = 1'b0;
		for (k = 0; k < tsws_pkg::MAX_ELEMENTS - 1; k++)
			offer_element(16'($urandom_range(1, 60)), 1'b0);
		offer_element(16'hFFFF, 1'b0);
		for (k = 0; k < 4; k++)
			offer_element(16'($urandom), k == 3);

		for (p = 5; p < 10; p++)
			random_phase(targets[p], 1'b0);

		settle();
		repeat (DRAIN_CYCLES) @(negedge clk);
		$display("Sent %0d elements in %0d arrays over %0d target settings.",
			elements_taken, arrays_sent, target_writes_done + 1);
		$display("Checked %0d found, %0d not found and %0d too-long results; %0d mismatches.",
			found_seen, not_found_seen, too_long_seen, mismatches);
		if (mismatches == 0)
			$display("target_sum_window_search_unit verification clean");
		else
			$display("target_sum_window_search_unit verification failed");
		$finish;
	end

endmodule

>>> sim.f
rtl/tsws_pkg.sv
rtl/tsws_ram.sv
rtl/tsws_fifo.sv
rtl/tsws_front.sv
rtl/tsws_back.sv
rtl/target_sum_window_search_unit.sv
tb/testbench.sv
